>>> rtl/core/nrtbs_pkg.sv
package nrtbs_pkg;

  localparam int TBL_N = 93;

  localparam logic [15:0] SMALL_LIMIT   = 16'd3824;
  localparam logic [15:0] LOW_RATE_SEG  = 16'd3816;
  localparam logic [15:0] HIGH_RATE_SEG = 16'd8424;
  localparam logic [4:0]  CRC_BITS      = 5'd24;
  localparam logic [11:0] RATE_ONE      = 12'd2048;
  localparam logic [11:0] RATE_QUARTER  = 12'd512;
  localparam logic [20:0] TBS_MAX       = 21'h1FFFFF;

  // ceil(2^s / seg) reciprocals, exact for 21-bit numerators
  localparam logic [23:0] RECIP_LOW        = 24'd2251032;
  localparam int          RECIP_LOW_SHIFT  = 33;
  localparam logic [23:0] RECIP_HIGH       = 24'd4078792;
  localparam int          RECIP_HIGH_SHIFT = 35;

  typedef logic [11:0] tbl_entry_t;

  function automatic tbl_entry_t tbs_table(input logic [6:0] idx);
    tbl_entry_t r;
    r = 12'd3824;
    case (idx)
      7'd0: r = 12'd24;     7'd1: r = 12'd32;     7'd2: r = 12'd40;
      7'd3: r = 12'd48;     7'd4: r = 12'd56;     7'd5: r = 12'd64;
      7'd6: r = 12'd72;     7'd7: r = 12'd80;     7'd8: r = 12'd88;
      7'd9: r = 12'd96;     7'd10: r = 12'd104;   7'd11: r = 12'd112;
      7'd12: r = 12'd120;   7'd13: r = 12'd128;   7'd14: r = 12'd136;
      7'd15: r = 12'd144;   7'd16: r = 12'd152;   7'd17: r = 12'd160;
      7'd18: r = 12'd168;   7'd19: r = 12'd176;   7'd20: r = 12'd184;
      7'd21: r = 12'd192;   7'd22: r = 12'd208;   7'd23: r = 12'd224;
      7'd24: r = 12'd240;   7'd25: r = 12'd256;   7'd26: r = 12'd272;
      7'd27: r = 12'd288;   7'd28: r = 12'd304;   7'd29: r = 12'd320;
      7'd30: r = 12'd336;   7'd31: r = 12'd352;   7'd32: r = 12'd368;
      7'd33: r = 12'd384;   7'd34: r = 12'd408;   7'd35: r = 12'd432;
      7'd36: r = 12'd456;   7'd37: r = 12'd480;   7'd38: r = 12'd504;
      7'd39: r = 12'd528;   7'd40: r = 12'd552;   7'd41: r = 12'd576;
      7'd42: r = 12'd608;   7'd43: r = 12'd640;   7'd44: r = 12'd672;
      7'd45: r = 12'd704;   7'd46: r = 12'd736;   7'd47: r = 12'd768;
      7'd48: r = 12'd808;   7'd49: r = 12'd848;   7'd50: r = 12'd888;
      7'd51: r = 12'd928;   7'd52: r = 12'd984;   7'd53: r = 12'd1032;
      7'd54: r = 12'd1064;  7'd55: r = 12'd1128;  7'd56: r = 12'd1160;
      7'd57: r = 12'd1192;  7'd58: r = 12'd1224;  7'd59: r = 12'd1256;
      7'd60: r = 12'd1288;  7'd61: r = 12'd1320;  7'd62: r = 12'd1352;
      7'd63: r = 12'd1416;  7'd64: r = 12'd1480;  7'd65: r = 12'd1544;
      7'd66: r = 12'd1608;  7'd67: r = 12'd1672;  7'd68: r = 12'd1736;
      7'd69: r = 12'd1800;  7'd70: r = 12'd1864;  7'd71: r = 12'd1928;
      7'd72: r = 12'd2024;  7'd73: r = 12'd2088;  7'd74: r = 12'd2152;
      7'd75: r = 12'd2216;  7'd76: r = 12'd2280;  7'd77: r = 12'd2408;
      7'd78: r = 12'd2472;  7'd79: r = 12'd2536;  7'd80: r = 12'd2600;
      7'd81: r = 12'd2664;  7'd82: r = 12'd2728;  7'd83: r = 12'd2792;
      7'd84: r = 12'd2856;  7'd85: r = 12'd2976;  7'd86: r = 12'd3104;
      7'd87: r = 12'd3240;  7'd88: r = 12'd3368;  7'd89: r = 12'd3496;
      7'd90: r = 12'd3624;  7'd91: r = 12'd3752;  7'd92: r = 12'd3824;
      default: r = 12'd3824;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/nrtbs_if.sv
interface nrtbs_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] num_blocks;
  logic [3:0] symbols_per_slot;
  logic [11:0] code_rate_x2048;
  logic [3:0] modulation_order;
  logic [2:0] layer_count;
  modport source (output valid, num_blocks, symbols_per_slot, code_rate_x2048,
                  modulation_order, layer_count, input ready);
  modport sink (input valid, num_blocks, symbols_per_slot, code_rate_x2048,
                modulation_order, layer_count, output ready);
endinterface

interface nrtbs_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] tbs_bits;
  logic [15:0] resource_elements;
  modport source (output valid, tbs_bits, resource_elements, input ready);
  modport sink (input valid, tbs_bits, resource_elements, output ready);
endinterface

interface nrtbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/nr_transport_block_size.sv
// Transport block size per TS 38.214 5.1.3.2. One query is one transfer in and one
// transfer out; the block is busy in between and takes a new query the cycle after
// the result transfer. The result is presented after the product chain for a zero
// size, after the table scan up to the first match for small sizes, after the
// ceiling division for large sizes with one code block and after the reciprocal
// segment count and the ceiling division otherwise. A sequencer reuses one
// registered multiplier for the product chain, the reciprocal segment count, the
// divisor 8c and the final size, and runs an 11-step compare-subtract for the
// ceiling over 8c and a one-entry-per-cycle table scan.
module nr_transport_block_size
  import nrtbs_pkg::*;
#(
  parameter int MAX_BLOCKS = 275,
  parameter int RE_CAP_PER_BLOCK = 156
)(
  input logic clk,
  input logic rst_n,
  nrtbs_in_if.sink    in_ch,
  nrtbs_out_if.source out_ch,
  nrtbs_cfg_if.sink   cfg_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_NI, S_FIN, S_SCAN, S_RMUL, S_RCAP,
    S_CMUL, S_CEIL, S_DIV, S_PMUL, S_TBS, S_OUT
  } state_t;

  state_t      st_r;
  logic [7:0]  ovh_r;
  logic [8:0]  blk_r;
  logic [7:0]  pb_r;
  logic [11:0] rate_r;
  logic [3:0]  qm_r;
  logic [2:0]  lay_r;
  logic [22:0] ninfo_r;
  logic [22:0] tot_r;
  logic [22:0] rem_r;
  logic [13:0] dvs_r;
  logic [10:0] cnt_r;
  logic [4:0]  bit_r;
  logic [6:0]  idx_r;
  logic [11:0] q_small_r;
  logic [20:0] tbs_r;
  logic [15:0] re_r;
  logic        low_r;
  logic [23:0] ma, mb;
  logic [47:0] mp;

  nrtbs_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(mp));

  // per-block REs from current cfg and input
  logic [7:0]  pbc;
  always_comb begin
    logic [7:0] s12;
    s12 = 8'(in_ch.symbols_per_slot) * 8'd12;
    pbc = (s12 > ovh_r) ? s12 - ovh_r : 8'd0;
    if (pbc > 8'(RE_CAP_PER_BLOCK)) pbc = 8'(RE_CAP_PER_BLOCK);
  end

  // quantization helpers for ninfo
  logic [4:0]  lg;
  logic [22:0] xl;
  logic [4:0]  lgx;
  always_comb begin
    lg = 5'd0;
    for (int i = 0; i < 23; i++) if (ninfo_r[i]) lg = 5'(i);
    xl = ninfo_r - 23'(CRC_BITS);
    lgx = 5'd0;
    for (int i = 0; i < 23; i++) if (xl[i]) lgx = 5'(i);
  end

  logic [4:0]  ns;
  logic [11:0] qs;
  logic [4:0]  nl;
  logic [22:0] ql;
  always_comb begin
    ns = (lg > 5'd9) ? lg - 5'd6 : 5'd3;
    qs = 12'((ninfo_r >> ns) << ns);
    if (qs < 12'(CRC_BITS)) qs = 12'(CRC_BITS);
    nl = lgx - 5'd5;
    ql = ((xl + (23'd1 << (nl - 5'd1))) >> nl) << nl;
    if (ql < 23'd3840) ql = 23'd3840;
  end

  logic [22:0] sub_try;
  assign sub_try = rem_r - (23'(dvs_r) << bit_r);

  always_comb begin
    ma = 24'(blk_r);
    mb = 24'(pb_r);
    unique case (st_r)
      S_M1: begin ma = 24'(blk_r); mb = 24'(pb_r); end
      S_M2: begin ma = mp[23:0]; mb = 24'(qm_r); end
      S_M3: begin ma = mp[23:0]; mb = 24'(lay_r); end
      S_M4: begin ma = mp[23:0]; mb = 24'(rate_r); end
      S_RMUL: begin
        ma = 24'(tot_r + 23'(low_r ? LOW_RATE_SEG : HIGH_RATE_SEG) - 23'd1);
        mb = low_r ? RECIP_LOW : RECIP_HIGH;
      end
      S_CMUL: begin ma = 24'(cnt_r); mb = 24'd8; end
      S_PMUL: begin ma = 24'(cnt_r); mb = 24'(dvs_r); end
      default: begin ma = 24'(blk_r); mb = 24'(pb_r); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovh_r <= 8'd1;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) ovh_r <= cfg_ch.data;
      unique case (st_r)
        S_IDLE: if (in_ch.valid) begin
          blk_r <= (in_ch.num_blocks > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : in_ch.num_blocks;
          pb_r  <= pbc;
          rate_r <= (in_ch.code_rate_x2048 > RATE_ONE) ? RATE_ONE : in_ch.code_rate_x2048;
          qm_r  <= (in_ch.modulation_order > 4'd8) ? 4'd8 : in_ch.modulation_order;
          lay_r <= (in_ch.layer_count > 3'd4) ? 3'd4 : in_ch.layer_count;
          st_r  <= S_M1;
        end
        S_M1: begin
          low_r <= (rate_r <= RATE_QUARTER);
          st_r <= S_M2;
        end
        S_M2: begin re_r <= mp[15:0]; st_r <= S_M3; end
        S_M3: st_r <= S_M4;
        S_M4: st_r <= S_NI;
        S_NI: begin
          ninfo_r <= 23'(mp >> 11);
          st_r <= S_FIN;
          idx_r <= 7'd0;
        end
        S_FIN: begin
          if (ninfo_r == 23'd0) begin
            tbs_r <= 21'd0; st_r <= S_OUT;
          end else if (ninfo_r <= 23'(SMALL_LIMIT)) begin
            q_small_r <= qs; st_r <= S_SCAN;
          end else begin
            tot_r <= ql + 23'(CRC_BITS);
            if (!low_r && ql <= 23'(HIGH_RATE_SEG)) begin
              cnt_r <= 11'd1; st_r <= S_CMUL;
            end else st_r <= S_RMUL;
          end
        end
        S_SCAN: begin
          if (tbs_table(idx_r) >= q_small_r || idx_r == 7'(TBL_N - 1)) begin
            tbs_r <= 21'(tbs_table(idx_r)); st_r <= S_OUT;
          end else idx_r <= idx_r + 7'd1;
        end
        S_RMUL: st_r <= S_RCAP;
        S_RCAP: begin
          // segment count c = ceil(tot/seg)
          cnt_r <= low_r ? 11'(mp >> RECIP_LOW_SHIFT) : 11'(mp >> RECIP_HIGH_SHIFT);
          st_r <= S_CMUL;
        end
        S_CMUL: st_r <= S_CEIL;
        S_CEIL: begin
          // d = 8c; count = ceil(tot/d)
          dvs_r <= mp[13:0];
          rem_r <= tot_r + 23'(mp[13:0]) - 23'd1;
          cnt_r <= 11'd0;
          bit_r <= 5'd10;
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (rem_r >= (23'(dvs_r) << bit_r)) begin
            rem_r <= sub_try; cnt_r[bit_r[3:0]] <= 1'b1;
          end
          if (bit_r == 5'd0) st_r <= S_PMUL;
          else bit_r <= bit_r - 5'd1;
        end
        S_PMUL: st_r <= S_TBS;
        S_TBS: begin
          tbs_r <= 21'(mp - 48'(CRC_BITS));
          st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.tbs_bits = tbs_r;
  assign out_ch.resource_elements = re_r;
endmodule

>>> rtl/core/nrtbs_mul.sv
// Shared 24x24 multiplier with registered product.
module nrtbs_mul
  import nrtbs_pkg::*;
(
  input  logic        clk,
  input  logic [23:0] a,
  input  logic [23:0] b,
  output logic [47:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
